// File: sv/bmprgba_pkg.sv
`default_nettype none

package bmprgba_pkg;

  // Result kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] ST_BAD_DEPTH    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED    = 3'd4;
  localparam logic [2:0] ST_BAD_OFFSET   = 3'd5;

  // Header byte positions
  localparam logic [31:0] POS_MAGIC_0  = 32'd0;
  localparam logic [31:0] POS_MAGIC_1  = 32'd1;
  localparam logic [31:0] POS_OFFS_LO  = 32'd10;
  localparam logic [31:0] POS_OFFS_HI  = 32'd11;
  localparam logic [31:0] POS_WIDTH_LO = 32'd18;
  localparam logic [31:0] POS_WIDTH_HI = 32'd19;
  localparam logic [31:0] POS_HEIGHT_0 = 32'd22;
  localparam logic [31:0] POS_HEIGHT_3 = 32'd25;
  localparam logic [31:0] POS_DEPTH    = 32'd28;

  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [7:0]  DEPTH_24     = 8'd24;
  localparam logic [7:0]  DEPTH_32     = 8'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [15:0] OFFSET_MIN   = 16'd30;
  localparam logic [32:0] HEADER_MIN   = 33'd54;

  // One result item
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] column;
    logic [30:0] row;
    logic [15:0] image_width;
    logic [31:0] image_height;
    logic [2:0]  status;
    logic        last_of_run;
  } result_t;

endpackage

`default_nettype wire

// File: sv/bmp_to_rgba_stream_decoder_unit.sv
`default_nettype none

// BMP to RGBA stream decoder. Takes a BMP file one byte per item and returns
// one pixel item per completed pixel (BGR(A) swapped to RGBA, alpha 255 for
// 24-bit files, row padding to four bytes skipped, rows in stored order),
// plus a status item on the byte flagged end_of_file, after which the
// decoder is back in its reset state and the next byte starts a new file.
// Header fields come from fixed positions: magic 'BM' at 0..1, 16-bit pixel
// offset at 10..11, 16-bit width at 18..19, signed 32-bit height at 22..25
// (magnitude used) and depth at 28 (24 or 32). Offsets below 30 are an
// error. Each byte is decoded in the cycle it is accepted, so one byte per
// clock is sustained while in_ready is high; a byte produces at most two
// result items, which enter a three-entry output queue. in_ready is high
// while the queue holds at most one item, so with a consumer that takes an
// item every cycle in_ready drops only after an end-of-file byte that also
// completes a pixel. The results of a byte are registered into the queue
// and reach the outputs once the items ahead of them have been taken.
module bmp_to_rgba_stream_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_file,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_item_kind,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [15:0]      out_column,
  output logic [30:0]      out_row,
  output logic [15:0]      out_image_width,
  output logic [31:0]      out_image_height,
  output logic [2:0]       out_status,
  output logic             out_last_of_run
);

  // Decoder state
  logic [31:0] pos_r,    pos_nxt;      // byte position in file, saturating
  logic [15:0] offset_r, offset_nxt;   // pixel data offset
  logic [15:0] width_r,  width_nxt;
  logic [31:0] height_r, height_nxt;   // height magnitude once byte 25 is in
  logic        four_r,   four_nxt;     // 32-bit pixels
  logic [2:0]  err_r,    err_nxt;      // first error seen
  logic [23:0] cb_r,     cb_nxt;       // collected B,G,R bytes
  logic [1:0]  ci_r,     ci_nxt;       // byte index inside the pixel
  logic [17:0] rbc_r,    rbc_nxt;      // bytes of the current row
  logic [15:0] col_r,    col_nxt;
  logic [31:0] rowc_r,   rowc_nxt;

  // Output queue: fixed slots, slot 0 is the head
  bmprgba_pkg::result_t q_r   [3];
  bmprgba_pkg::result_t q_nxt [3];
  bmprgba_pkg::result_t q_sh  [3];
  logic [1:0]           cnt_r, cnt_nxt, cnt_pop;

  logic                 in_fire, pop;
  bmprgba_pkg::result_t pix_res, stat_res, res0, res1;
  logic                 pix_emit;
  logic [1:0]           npush;

  logic        pix_phase;
  logic [15:0] offs_new;
  logic [31:0] hgt_ins;
  logic [23:0] cb_ins;
  logic [1:0]  last_ci;
  logic [32:0] total;
  logic [2:0]  st;

  assign in_ready  = (cnt_r <= 2'd1);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  // Pixel bytes follow the header and the offset, while rows remain.
  assign pix_phase = (err_r == bmprgba_pkg::ST_OK) && (pos_r >= 32'd30) &&
                     (pos_r >= {16'd0, offset_r}) && (width_r != 16'd0) &&
                     (rowc_r < height_r);

  assign offs_new = {in_data_byte, offset_r[7:0]};
  // height byte k sits at position 22+k; low two bits of pos minus 2 give k
  assign hgt_ins  = height_r |
                    ({24'd0, in_data_byte} << {pos_r[1:0] - 2'd2, 3'b000});
  assign cb_ins   = cb_r | ({16'd0, in_data_byte} << {ci_r, 3'b000});
  assign last_ci  = four_r ? 2'd3 : 2'd2;
  assign total    = {1'b0, pos_r} + 33'd1;

  always_comb begin
    pos_nxt    = pos_r;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    four_nxt   = four_r;
    err_nxt    = err_r;
    cb_nxt     = cb_r;
    ci_nxt     = ci_r;
    rbc_nxt    = rbc_r;
    col_nxt    = col_r;
    rowc_nxt   = rowc_r;
    pix_emit   = 1'b0;
    st         = bmprgba_pkg::ST_OK;

    pix_res              = '0;
    pix_res.item_kind    = bmprgba_pkg::KIND_PIXEL;
    pix_res.red          = cb_ins[23:16];
    pix_res.green        = cb_ins[15:8];
    pix_res.blue         = cb_ins[7:0];
    pix_res.alpha        = four_r ? in_data_byte : bmprgba_pkg::ALPHA_OPAQUE;
    pix_res.column       = col_r;
    pix_res.row          = rowc_r[30:0];
    pix_res.image_width  = width_r;
    pix_res.image_height = height_r;
    pix_res.status       = bmprgba_pkg::ST_OK;
    pix_res.last_of_run  = 1'b1;

    if (in_fire) begin
      priority if (pos_r == bmprgba_pkg::POS_MAGIC_0) begin
        if (in_data_byte != bmprgba_pkg::MAGIC_B && err_r == bmprgba_pkg::ST_OK)
          err_nxt = bmprgba_pkg::ST_BAD_MAGIC;
      end else if (pos_r == bmprgba_pkg::POS_MAGIC_1) begin
        if (in_data_byte != bmprgba_pkg::MAGIC_M && err_r == bmprgba_pkg::ST_OK)
          err_nxt = bmprgba_pkg::ST_BAD_MAGIC;
      end else if (pos_r == bmprgba_pkg::POS_OFFS_LO) begin
        offset_nxt = {offset_r[15:8], in_data_byte};
      end else if (pos_r == bmprgba_pkg::POS_OFFS_HI) begin
        offset_nxt = offs_new;
        if (offs_new < bmprgba_pkg::OFFSET_MIN && err_r == bmprgba_pkg::ST_OK)
          err_nxt = bmprgba_pkg::ST_BAD_OFFSET;
      end else if (pos_r == bmprgba_pkg::POS_WIDTH_LO) begin
        width_nxt = {width_r[15:8], in_data_byte};
      end else if (pos_r == bmprgba_pkg::POS_WIDTH_HI) begin
        width_nxt = {in_data_byte, width_r[7:0]};
      end else if (pos_r >= bmprgba_pkg::POS_HEIGHT_0 &&
                   pos_r <= bmprgba_pkg::POS_HEIGHT_3) begin
        // negative height: keep the magnitude
        if (pos_r == bmprgba_pkg::POS_HEIGHT_3 && hgt_ins[31])
          height_nxt = 32'd0 - hgt_ins;
        else
          height_nxt = hgt_ins;
      end else if (pos_r == bmprgba_pkg::POS_DEPTH) begin
        if (in_data_byte == bmprgba_pkg::DEPTH_24)
          four_nxt = 1'b0;
        else if (in_data_byte == bmprgba_pkg::DEPTH_32)
          four_nxt = 1'b1;
        else if (err_r == bmprgba_pkg::ST_OK)
          err_nxt = bmprgba_pkg::ST_BAD_DEPTH;
      end else if (pix_phase) begin
        if (col_r < width_r) begin
          if (ci_r != 2'd3)
            cb_nxt = cb_ins;
          if (ci_r == last_ci) begin
            pix_emit = 1'b1;
            col_nxt  = col_r + 16'd1;
            ci_nxt   = 2'd0;
            cb_nxt   = '0;
          end else begin
            ci_nxt = ci_r + 2'd1;
          end
        end
        rbc_nxt = rbc_r + 18'd1;
        // row done once all pixels and padding to four bytes are in
        if (col_nxt == width_r && rbc_nxt[1:0] == 2'b00) begin
          rowc_nxt = rowc_r + 32'd1;
          col_nxt  = '0;
          rbc_nxt  = '0;
        end
      end

      if (in_end_of_file) begin
        priority if (total < bmprgba_pkg::HEADER_MIN)
          st = bmprgba_pkg::ST_SHORT_HEADER;
        else if (err_nxt != bmprgba_pkg::ST_OK)
          st = err_nxt;
        else if (total >= {17'd0, offset_nxt} &&
                 (width_nxt == 16'd0 || rowc_nxt >= height_nxt))
          st = bmprgba_pkg::ST_OK;
        else
          st = bmprgba_pkg::ST_TRUNCATED;
      end
    end

    stat_res              = '0;
    stat_res.item_kind    = bmprgba_pkg::KIND_STATUS;
    stat_res.image_width  = width_nxt;
    stat_res.image_height = height_nxt;
    stat_res.status       = st;
    stat_res.last_of_run  = 1'b1;

    if (in_fire) begin
      if (in_end_of_file) begin
        // file done: back to reset state
        pos_nxt    = '0;
        offset_nxt = '0;
        width_nxt  = '0;
        height_nxt = '0;
        four_nxt   = 1'b0;
        err_nxt    = bmprgba_pkg::ST_OK;
        cb_nxt     = '0;
        ci_nxt     = '0;
        rbc_nxt    = '0;
        col_nxt    = '0;
        rowc_nxt   = '0;
      end else if (pos_r != 32'hFFFF_FFFF) begin
        pos_nxt = pos_r + 32'd1;
      end
    end
  end

  // Results of this byte, in order
  always_comb begin
    res0  = pix_res;
    res1  = stat_res;
    npush = 2'd0;
    if (in_fire) begin
      if (pix_emit && in_end_of_file) begin
        res0.last_of_run = 1'b0;
        npush            = 2'd2;
      end else if (pix_emit) begin
        npush = 2'd1;
      end else if (in_end_of_file) begin
        res0  = stat_res;
        npush = 2'd1;
      end
    end
  end

  // Queue: shift out the head on pop, append new results behind the rest
  assign cnt_pop = cnt_r - {1'b0, pop};
  assign cnt_nxt = cnt_pop + npush;

  always_comb begin
    q_sh[0] = pop ? q_r[1] : q_r[0];
    q_sh[1] = pop ? q_r[2] : q_r[1];
    q_sh[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt_pop)
        q_nxt[i] = q_sh[i];
      else if (2'(i) == cnt_pop)
        q_nxt[i] = res0;
      else
        q_nxt[i] = res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      four_r   <= 1'b0;
      err_r    <= bmprgba_pkg::ST_OK;
      cb_r     <= '0;
      ci_r     <= '0;
      rbc_r    <= '0;
      col_r    <= '0;
      rowc_r   <= '0;
      cnt_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      four_r   <= four_nxt;
      err_r    <= err_nxt;
      cb_r     <= cb_nxt;
      ci_r     <= ci_nxt;
      rbc_r    <= rbc_nxt;
      col_r    <= col_nxt;
      rowc_r   <= rowc_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      q_r[i] <= q_nxt[i];
  end

  assign out_item_kind    = q_r[0].item_kind;
  assign out_red          = q_r[0].red;
  assign out_green        = q_r[0].green;
  assign out_blue         = q_r[0].blue;
  assign out_alpha        = q_r[0].alpha;
  assign out_column       = q_r[0].column;
  assign out_row          = q_r[0].row;
  assign out_image_width  = q_r[0].image_width;
  assign out_image_height = q_r[0].image_height;
  assign out_status       = q_r[0].status;
  assign out_last_of_run  = q_r[0].last_of_run;

  // Pixel items never carry a status code
  a_pixel_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == bmprgba_pkg::KIND_PIXEL |->
      out_status == bmprgba_pkg::ST_OK)
    else $error("pixel item with nonzero status");

  // The status item always closes the run of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == bmprgba_pkg::KIND_STATUS |-> out_last_of_run)
    else $error("status item not last of run");

  // End of file returns the parser to the start of a new file
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_file |=> pos_r == 32'd0 && err_r == bmprgba_pkg::ST_OK &&
      rowc_r == 32'd0)
    else $error("state not cleared after end of file");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`default_nettype none

module testbench;

  // Run sizing for the slowest correct run: about 1.6k bytes, at most two
  // results per byte, both sides idling a quarter of the time, plus one long
  // receiver hold.
  localparam int RAND_BYTES   = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;
  localparam int N_KINDS      = 14;
  localparam int MAX_REPORTS  = 10;

  // Shapes of generated files. The first pass walks every kind once, after
  // that well-formed files dominate.
  typedef enum int {
    FK_OK24, FK_OK32, FK_NEG_HEIGHT, FK_EARLY_PIX, FK_EARLY_SHORT, FK_TRUNC,
    FK_HUGE, FK_ZERO_W, FK_ZERO_H, FK_FAR_OFFSET, FK_BAD_MAGIC, FK_BAD_OFFSET,
    FK_BAD_DEPTH, FK_NOISE
  } file_kind_t;

  // Mirror of the decoder: takes each accepted byte, queues the result items
  // it should produce, and compares the DUT output stream against that queue.
  class bmp_scoreboard;
    bmprgba_pkg::result_t want_q[$];
    logic [31:0] byte_pos;
    logic [15:0] pix_offset;
    logic [15:0] img_w;
    logic [31:0] img_h;
    logic        four_ch;
    logic [2:0]  err;
    logic [23:0] chan_acc;
    logic [1:0]  chan_idx;
    logic [17:0] row_bytes;
    logic [15:0] col_cnt;
    logic [31:0] row_cnt;
    int          n_fail, n_checked, n_bytes, n_pix, n_pix32, n_status;
    int          st_seen[8];

    function new();
      clear_state();
    endfunction

    function void clear_state();
      byte_pos   = '0;
      pix_offset = '0;
      img_w      = '0;
      img_h      = '0;
      four_ch    = 1'b0;
      err        = bmprgba_pkg::ST_OK;
      chan_acc   = '0;
      chan_idx   = '0;
      row_bytes  = '0;
      col_cnt    = '0;
      row_cnt    = '0;
    endfunction

    function void flag(logic [2:0] code);
      if (err == bmprgba_pkg::ST_OK) err = code;
    endfunction

    function bmprgba_pkg::result_t make(logic kind, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, logic [7:0] a, logic [15:0] col,
                                        logic [30:0] row, logic [2:0] st);
      bmprgba_pkg::result_t res;
      res.item_kind    = kind;
      res.red          = r;
      res.green        = g;
      res.blue         = b;
      res.alpha        = a;
      res.column       = col;
      res.row          = row;
      res.image_width  = img_w;
      res.image_height = img_h;
      res.status       = st;
      res.last_of_run  = 1'b0;
      return res;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      bmprgba_pkg::result_t made[$];
      logic [31:0] p;
      logic [1:0]  last_ch;
      logic [32:0] total;
      logic [2:0]  st;
      p = byte_pos;
      n_bytes++;
      if (p == bmprgba_pkg::POS_MAGIC_0) begin
        if (b != bmprgba_pkg::MAGIC_B) flag(bmprgba_pkg::ST_BAD_MAGIC);
      end else if (p == bmprgba_pkg::POS_MAGIC_1) begin
        if (b != bmprgba_pkg::MAGIC_M) flag(bmprgba_pkg::ST_BAD_MAGIC);
      end else if (p == bmprgba_pkg::POS_OFFS_LO) begin
        pix_offset[7:0] = b;
      end else if (p == bmprgba_pkg::POS_OFFS_HI) begin
        pix_offset[15:8] = b;
        if (pix_offset < bmprgba_pkg::OFFSET_MIN) flag(bmprgba_pkg::ST_BAD_OFFSET);
      end else if (p == bmprgba_pkg::POS_WIDTH_LO) begin
        img_w[7:0] = b;
      end else if (p == bmprgba_pkg::POS_WIDTH_HI) begin
        img_w[15:8] = b;
      end else if (p >= bmprgba_pkg::POS_HEIGHT_0 && p <= bmprgba_pkg::POS_HEIGHT_3) begin
        img_h[8*(p - bmprgba_pkg::POS_HEIGHT_0) +: 8] = b;
        // negative height: stored top-down, only the magnitude matters
        if (p == bmprgba_pkg::POS_HEIGHT_3 && img_h[31]) img_h = 32'd0 - img_h;
      end else if (p == bmprgba_pkg::POS_DEPTH) begin
        if (b == bmprgba_pkg::DEPTH_24) four_ch = 1'b0;
        else if (b == bmprgba_pkg::DEPTH_32) four_ch = 1'b1;
        else flag(bmprgba_pkg::ST_BAD_DEPTH);
      end else if (err == bmprgba_pkg::ST_OK && p >= 32'(bmprgba_pkg::OFFSET_MIN) &&
                   p >= 32'(pix_offset) && img_w != 0 && row_cnt < img_h) begin
        last_ch = four_ch ? 2'd3 : 2'd2;
        if (col_cnt < img_w) begin
          if (chan_idx != 2'd3) chan_acc[8*chan_idx +: 8] = b;
          if (chan_idx == last_ch) begin
            // stored as B,G,R(,A)
            made = {made, make(bmprgba_pkg::KIND_PIXEL, chan_acc[23:16], chan_acc[15:8],
                               chan_acc[7:0], four_ch ? b : bmprgba_pkg::ALPHA_OPAQUE,
                               col_cnt, row_cnt[30:0], bmprgba_pkg::ST_OK)};
            n_pix++;
            if (four_ch) n_pix32++;
            col_cnt++;
            chan_idx = '0;
            chan_acc = '0;
          end else begin
            chan_idx++;
          end
        end
        row_bytes++;
        // row done once all pixels are in and padding reaches a 4-byte boundary
        if (col_cnt == img_w && row_bytes[1:0] == 2'd0) begin
          row_cnt++;
          col_cnt   = '0;
          row_bytes = '0;
        end
      end

      if (eof) begin
        total = {1'b0, p} + 33'd1;
        if (total < bmprgba_pkg::HEADER_MIN) st = bmprgba_pkg::ST_SHORT_HEADER;
        else if (err != bmprgba_pkg::ST_OK) st = err;
        else if (total >= {17'd0, pix_offset} && (img_w == 0 || row_cnt >= img_h))
          st = bmprgba_pkg::ST_OK;
        else st = bmprgba_pkg::ST_TRUNCATED;
        made = {made, make(bmprgba_pkg::KIND_STATUS, '0, '0, '0, '0, '0, '0, st)};
        n_status++;
        st_seen[st]++;
        clear_state();
      end else if (byte_pos != 32'hFFFF_FFFF) begin
        byte_pos++;
      end

      if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
      foreach (made[i]) want_q = {want_q, made[i]};
    endfunction

    function string show(bmprgba_pkg::result_t r);
      return $sformatf({"kind=%0d rgba=%02h_%02h_%02h_%02h col=%0d row=%0d",
                        " w=%0d h=%0d st=%0d last=%0d"},
                       r.item_kind, r.red, r.green, r.blue, r.alpha, r.column, r.row,
                       r.image_width, r.image_height, r.status, r.last_of_run);
    endfunction

    function void check_result(bmprgba_pkg::result_t got);
      bmprgba_pkg::result_t want;
      n_checked++;
      if (want_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("result %0d with nothing pending: %s", n_checked, show(got));
        return;
      end
      want = want_q.pop_front();
      if (got.item_kind !== want.item_kind || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.column !== want.column ||
          got.row !== want.row || got.image_width !== want.image_width ||
          got.image_height !== want.image_height || got.status !== want.status ||
          got.last_of_run !== want.last_of_run) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
          $display("mismatch on result %0d", n_checked);
          $display("  want %s", show(want));
          $display("  got  %s", show(got));
        end
      end
    endfunction

    function void check_leftover();
      if (want_q.size() != 0) begin
        n_fail++;
        $display("%0d result items never arrived", want_q.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_end_of_file;
  logic        out_valid;
  logic        out_ready;
  logic        out_item_kind;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [15:0] out_column;
  logic [30:0] out_row;
  logic [15:0] out_image_width;
  logic [31:0] out_image_height;
  logic [2:0]  out_status;
  logic        out_last_of_run;

  bmp_scoreboard sb;
  logic [7:0]    file_bytes[$];   // file being sent
  int            cycles = 0;
  int            file_no = 0;
  int            sent_bytes = 0;
  bit            calm = 1'b0;     // both sides stop idling while set
  bit            hold_req = 1'b0; // sender asks receiver for its long hold
  bit            hold_taken = 1'b0;
  int            hold_left = 0;

  always #1 clk = ~clk;

  bmp_to_rgba_stream_decoder_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run)
  );

  // Watchdog. Nothing legal comes close to this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Monitor: one process handles both channels so a byte is always predicted
  // before any result in the same cycle is checked, whatever the DUT latency.
  always @(posedge clk) begin
    bmprgba_pkg::result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_end_of_file);
      if (out_valid && out_ready) begin
        got.item_kind    = out_item_kind;
        got.red          = out_red;
        got.green        = out_green;
        got.blue         = out_blue;
        got.alpha        = out_alpha;
        got.column       = out_column;
        got.row          = out_row;
        got.image_width  = out_image_width;
        got.image_height = out_image_height;
        got.status       = out_status;
        got.last_of_run  = out_last_of_run;
        sb.check_result(got);
      end
    end
  end

  // Result consumer: random backpressure, one long hold on request so the
  // three-entry output queue backs up and in_ready drops while bytes keep coming.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99, 0) >= 26);
      end
    end
  end

  // Offer one byte, called at a falling edge. Returns at the falling edge
  // after acceptance, with valid still high; the caller's next drive decides.
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while (!calm && $urandom_range(99, 0) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      push_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Sender pause: drop valid and wait until every expected item is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Weighted pick for the random phase: mostly well-formed files with random
  // content so the pixel path gets exercised, the rest broken or noise.
  function automatic file_kind_t pick_kind();
    int r;
    r = $urandom_range(99, 0);
    if (r < 18) return FK_OK24;
    if (r < 36) return FK_OK32;
    if (r < 46) return FK_NEG_HEIGHT;
    if (r < 56) return FK_EARLY_PIX;
    if (r < 64) return FK_TRUNC;
    if (r < 68) return FK_EARLY_SHORT;
    if (r < 72) return FK_HUGE;
    if (r < 76) return FK_ZERO_W;
    if (r < 80) return FK_ZERO_H;
    if (r < 83) return FK_FAR_OFFSET;
    if (r < 87) return FK_BAD_MAGIC;
    if (r < 91) return FK_BAD_OFFSET;
    if (r < 95) return FK_BAD_DEPTH;
    return FK_NOISE;
  endfunction

  // Build a file image of the given shape into file_bytes. Pixel and filler
  // bytes are random; only the parsed header fields are set on purpose.
  function automatic void build_file(input file_kind_t k);
    int          w, h, off, bpp, rowpad, hdr, extra, full, len, sel;
    logic [31:0] hv;
    logic [7:0]  dep, m0, m1, v;
    bit          neg;
    file_bytes.delete();
    if (k == FK_NOISE) begin
      len = $urandom_range(80, 1);
      repeat (len) file_bytes = {file_bytes, 8'($urandom)};
      return;
    end
    w     = $urandom_range(5, 1);
    h     = $urandom_range(4, 1);
    dep   = $urandom_range(1, 0) ? bmprgba_pkg::DEPTH_32 : bmprgba_pkg::DEPTH_24;
    off   = ($urandom_range(3, 0) == 0) ? $urandom_range(53, 30) : $urandom_range(64, 54);
    neg   = $urandom_range(1, 0);
    extra = $urandom_range(6, 0);
    m0    = bmprgba_pkg::MAGIC_B;
    m1    = bmprgba_pkg::MAGIC_M;
    case (k)
      FK_OK24:        dep = bmprgba_pkg::DEPTH_24;
      FK_OK32:        dep = bmprgba_pkg::DEPTH_32;
      FK_NEG_HEIGHT:  neg = 1'b1;
      FK_EARLY_PIX:   off = $urandom_range(53, 30);
      FK_EARLY_SHORT: off = $urandom_range(50, 30);
      FK_TRUNC:       extra = 0;
      FK_ZERO_W:      w = 0;
      FK_ZERO_H:      h = 0;
      FK_FAR_OFFSET:  off = $urandom_range(65535, 256);
      FK_HUGE:        w = $urandom_range(65535, 32768);
      FK_BAD_MAGIC: begin
        sel = $urandom_range(2, 0);
        if (sel != 1) do m0 = 8'($urandom); while (m0 == bmprgba_pkg::MAGIC_B);
        if (sel != 0) do m1 = 8'($urandom); while (m1 == bmprgba_pkg::MAGIC_M);
        // later errors must not win over the magic
        if ($urandom_range(1, 0)) off = $urandom_range(29, 0);
      end
      FK_BAD_OFFSET: begin
        off = $urandom_range(29, 0);
        if ($urandom_range(1, 0))
          do dep = 8'($urandom);
          while (dep == bmprgba_pkg::DEPTH_24 || dep == bmprgba_pkg::DEPTH_32);
      end
      FK_BAD_DEPTH:
        do dep = 8'($urandom);
        while (dep == bmprgba_pkg::DEPTH_24 || dep == bmprgba_pkg::DEPTH_32);
      default: ;
    endcase
    hv = neg ? (32'd0 - 32'(h)) : 32'(h);
    if (k == FK_HUGE) hv = $urandom_range(1, 0) ? 32'h8000_0000 : $urandom();
    bpp    = (dep == bmprgba_pkg::DEPTH_32) ? 4 : 3;
    rowpad = (w * bpp + 3) / 4 * 4;
    hdr    = (off < 30) ? 54 : off;
    full   = hdr + rowpad * h + extra;
    if (k == FK_EARLY_PIX && full < 54) full = 54;
    len = full;
    case (k)
      FK_TRUNC:       len = $urandom_range(full - 1, off);
      FK_EARLY_SHORT: len = $urandom_range(53, off + 1);
      FK_HUGE:        len = off + $urandom_range(40, 12);
      FK_FAR_OFFSET:  len = $urandom_range(120, 54);
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom);
      case (32'(i))
        bmprgba_pkg::POS_MAGIC_0:  v = m0;
        bmprgba_pkg::POS_MAGIC_1:  v = m1;
        bmprgba_pkg::POS_OFFS_LO:  v = off[7:0];
        bmprgba_pkg::POS_OFFS_HI:  v = off[15:8];
        bmprgba_pkg::POS_WIDTH_LO: v = w[7:0];
        bmprgba_pkg::POS_WIDTH_HI: v = w[15:8];
        bmprgba_pkg::POS_HEIGHT_0, bmprgba_pkg::POS_HEIGHT_0 + 1,
        bmprgba_pkg::POS_HEIGHT_0 + 2, bmprgba_pkg::POS_HEIGHT_3:
          v = hv[8*(i - bmprgba_pkg::POS_HEIGHT_0) +: 8];
        bmprgba_pkg::POS_DEPTH:    v = dep;
        default: ;
      endcase
      file_bytes = {file_bytes, v};
    end
  endfunction

  // Main sequence.
  initial begin
    file_kind_t k;
    int         rand_start;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_end_of_file = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: tiny files. All-zeros and all-ones single bytes, lone 'B',
    // a full magic that ends early, a bad first magic byte, and a run of
    // 0xFF that ends inside the header. All must report short header.
    file_bytes = '{8'h00};                                         send_file();
    file_bytes = '{8'hFF};                                         send_file();
    file_bytes = '{bmprgba_pkg::MAGIC_B};                          send_file();
    file_bytes = '{bmprgba_pkg::MAGIC_B, bmprgba_pkg::MAGIC_M};    send_file();
    file_bytes = '{8'h00, bmprgba_pkg::MAGIC_M};                   send_file();
    file_bytes.delete();
    repeat (16) file_bytes = {file_bytes, 8'hFF};
    send_file();
    wait_drained();

    // Random phase: one file of every kind first, then weighted picks.
    rand_start = sent_bytes;
    while (sent_bytes - rand_start < RAND_BYTES) begin
      k = (file_no < N_KINDS) ? file_kind_t'(file_no) : pick_kind();
      calm = (file_no >= 20 && file_no < 25);
      // second file is built as a 32-bit image: hold the output on it
      if (file_no == 1) hold_req = 1'b1;
      build_file(k);
      send_file();
      if (file_no == N_KINDS - 1 || file_no == 30) wait_drained();
      file_no++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.check_leftover();

    $display("covered %0d bytes in %0d files, %0d pixels (%0d 32-bit), %0d items checked",
             sb.n_bytes, sb.n_status, sb.n_pix, sb.n_pix32, sb.n_checked);
    $display("end status mix: ok %0d short %0d magic %0d depth %0d trunc %0d offset %0d",
             sb.st_seen[bmprgba_pkg::ST_OK], sb.st_seen[bmprgba_pkg::ST_SHORT_HEADER],
             sb.st_seen[bmprgba_pkg::ST_BAD_MAGIC], sb.st_seen[bmprgba_pkg::ST_BAD_DEPTH],
             sb.st_seen[bmprgba_pkg::ST_TRUNCATED], sb.st_seen[bmprgba_pkg::ST_BAD_OFFSET]);
    if (sb.n_fail == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d failures", sb.n_fail);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/bmprgba_pkg.sv
sv/bmp_to_rgba_stream_decoder_unit.sv
dv/testbench.sv
